>>> sv/three_wire_register_port_master_top_macros.svh
// assertion macros used by the register port master back end
`ifndef THREE_WIRE_REGISTER_PORT_MASTER_TOP_MACROS_SVH
`define THREE_WIRE_REGISTER_PORT_MASTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define TRPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("trpm assertion failed");
`define TRPM_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("trpm forbidden condition seen");
`else
`define TRPM_ASSERT(lbl, clk, rst_n, prop)
`define TRPM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> sv/trpm_pkg.sv
// types and constants of the three-wire register port master
package trpm_pkg;

    localparam int WRITE_BITS_DEF = 32;
    localparam int READ_BITS_DEF  = 16;
    localparam int WORD_W         = 32;
    localparam int READ_WORD_W    = 16;
    localparam int PHASE_W        = 16;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd4;
    localparam int Q_DEPTH        = 2;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_CE       = 4'd1,
        ST_SETUP    = 4'd2,
        ST_HIGH     = 4'd3,
        ST_TAIL     = 4'd4,
        ST_LATCH    = 4'd5,
        ST_RB_PREP  = 4'd6,
        ST_RB_DUMMY = 4'd7,
        ST_RB_LATCH = 4'd8,
        ST_RB_HIGH  = 4'd9,
        ST_RB_LOW   = 4'd10,
        ST_RB_END   = 4'd11
    } t_step;

    // one classified tick
    typedef struct packed {
        logic              start;
        logic              readback;
        logic              device;
        logic [WORD_W-1:0] word;
        logic              sample;
    } t_cmd;

    typedef struct packed {
        logic                   clock_pin;
        logic                   data_pin;
        logic                   latch_first;
        logic                   latch_second;
        logic                   enable_first;
        logic                   enable_second;
        logic                   busy_res;
        logic [READ_WORD_W-1:0] read_word;
        logic                   read_done;
    } t_res;

endpackage

>>> sv/trpm_front.sv
// front end: takes input beats and classifies the requested action
module trpm_front
    import trpm_pkg::*;
#(
    parameter int WRITE_BITS = WRITE_BITS_DEF
) (
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [1:0]        action;
    logic [WORD_W-1:0] word;

    assign action = i_s_axis_tdata[1:0];
    assign word   = i_s_axis_tdata[WORD_W+2:3];

    assign o_s_axis_tready = i_q_ready;
    assign o_push          = i_s_axis_tvalid & i_q_ready;

    always_comb begin
        o_cmd.start    = action inside {ACT_WRITE, ACT_READ};
        o_cmd.readback = (action == ACT_READ);
        o_cmd.device   = i_s_axis_tdata[2];
        // only the low bits of the word go out on the wire
        o_cmd.word     = WORD_W'(word[WRITE_BITS-1:0]);
        o_cmd.sample   = i_s_axis_tdata[WORD_W+3];
    end

endmodule

>>> sv/trpm_queue.sv
// short queue of classified ticks between front end and sequencer
module trpm_queue
    import trpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PtrW = $clog2(Q_DEPTH);
    localparam int CntW = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [PtrW-1:0] r_wp, n_wp;
    logic [PtrW-1:0] r_rp, n_rp;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_ready = (r_cnt != CntW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + PtrW'(1) : r_wp;
        n_rp  = i_pop ? r_rp + PtrW'(1) : r_rp;
        n_cnt = r_cnt + CntW'(i_push) - CntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> sv/trpm_back.sv
// back end: pin sequencer, phase register and result register
`include "three_wire_register_port_master_top_macros.svh"
module trpm_back
    import trpm_pkg::*;
#(
    parameter int WRITE_BITS = WRITE_BITS_DEF,
    parameter int READ_BITS  = READ_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [PHASE_W-1:0] i_cfg_wr_data,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output t_res               o_res
);

    localparam int MaxBits = (WRITE_BITS > READ_BITS) ? WRITE_BITS : READ_BITS;
    localparam int CntW    = $clog2(MaxBits + 1);

    logic [PHASE_W-1:0]    r_phase;
    t_step                 r_step, n_step;
    logic [PHASE_W-1:0]    r_tick, n_tick;
    logic [CntW-1:0]       r_bits, n_bits;
    logic [WRITE_BITS-1:0] r_oshift, n_oshift;
    logic [READ_BITS-1:0]  r_ishift, n_ishift;
    logic                  r_dev, n_dev;
    logic                  r_rb, n_rb;
    logic [1:0]            r_en, n_en;
    logic [1:0]            r_lat, n_lat;
    logic                  r_clk, n_clk;
    logic                  r_data, n_data;
    logic                  n_done;
    t_res                  r_out, n_out;
    logic                  r_out_valid;

    logic [PHASE_W-1:0] hold;
    logic [PHASE_W-1:0] tick_inc;
    logic [CntW-1:0]    bits_inc;
    logic               adv;

    // a fresh tick is taken whenever the result register is free or drains
    assign o_pop   = i_q_valid & (~r_out_valid | i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    assign hold     = (r_phase == '0) ? PHASE_W'(1) : r_phase;
    assign tick_inc = r_tick + PHASE_W'(1);
    assign bits_inc = r_bits + CntW'(1);
    assign adv      = (tick_inc >= hold);

    // next step
    always_comb begin
        n_step = r_step;
        if (r_step == ST_IDLE) begin
            if (i_cmd.start) n_step = ST_CE;
        end else if (adv) begin
            case (r_step)
                ST_CE:       n_step = ST_SETUP;
                ST_SETUP:    n_step = ST_HIGH;
                ST_HIGH:     n_step = (bits_inc >= CntW'(WRITE_BITS)) ? ST_TAIL : ST_SETUP;
                ST_TAIL:     n_step = ST_LATCH;
                ST_LATCH:    n_step = r_rb ? ST_RB_PREP : ST_IDLE;
                ST_RB_PREP:  n_step = ST_RB_DUMMY;
                ST_RB_DUMMY: n_step = ST_RB_LATCH;
                ST_RB_LATCH: n_step = ST_RB_HIGH;
                ST_RB_HIGH:  n_step = ST_RB_LOW;
                ST_RB_LOW:   n_step = (r_bits >= CntW'(READ_BITS)) ? ST_RB_END : ST_RB_HIGH;
                ST_RB_END:   n_step = ST_IDLE;
                default:     n_step = ST_IDLE;
            endcase
        end
    end

    // pins, counters and shifters
    always_comb begin
        n_tick   = r_tick;
        n_bits   = r_bits;
        n_oshift = r_oshift;
        n_ishift = r_ishift;
        n_dev    = r_dev;
        n_rb     = r_rb;
        n_en     = r_en;
        n_lat    = r_lat;
        n_clk    = r_clk;
        n_data   = r_data;
        n_done   = 1'b0;
        if (r_step == ST_IDLE) begin
            if (i_cmd.start) begin
                n_dev              = i_cmd.device;
                n_rb               = i_cmd.readback;
                n_oshift           = i_cmd.word[WRITE_BITS-1:0];
                n_en[i_cmd.device] = 1'b1;
                n_tick             = '0;
                n_bits             = '0;
            end
        end else begin
            n_tick = adv ? '0 : tick_inc;
            if (adv) begin
                case (r_step)
                    ST_CE: begin
                        n_lat[r_dev] = 1'b0;
                        n_clk        = 1'b0;
                        n_bits       = '0;
                        n_data       = r_oshift[WRITE_BITS-1];
                    end
                    ST_SETUP: begin
                        n_clk = 1'b1;
                    end
                    ST_HIGH: begin
                        n_clk    = 1'b0;
                        n_oshift = {r_oshift[WRITE_BITS-2:0], 1'b0};
                        n_bits   = bits_inc;
                        if (bits_inc < CntW'(WRITE_BITS)) n_data = r_oshift[WRITE_BITS-2];
                    end
                    ST_TAIL: begin
                        n_lat[r_dev] = 1'b1;
                    end
                    ST_LATCH: begin
                        n_lat[r_dev] = 1'b0;
                        if (r_rb) begin
                            n_clk  = 1'b0;
                            n_data = 1'b1;
                        end
                    end
                    ST_RB_PREP: begin
                        n_clk = 1'b1;
                    end
                    ST_RB_DUMMY: begin
                        n_clk        = 1'b0;
                        n_data       = 1'b0;
                        n_lat[r_dev] = 1'b1;
                        n_ishift     = '0;
                        n_bits       = '0;
                    end
                    ST_RB_LATCH: begin
                        n_clk = 1'b1;
                    end
                    ST_RB_HIGH: begin
                        // sample on the last tick of clock high
                        n_ishift = {r_ishift[READ_BITS-2:0], i_cmd.sample};
                        n_bits   = bits_inc;
                        n_clk    = 1'b0;
                    end
                    ST_RB_LOW: begin
                        n_clk = 1'b1;
                    end
                    ST_RB_END: begin
                        n_lat[r_dev] = 1'b0;
                        n_clk        = 1'b0;
                        n_done       = 1'b1;
                    end
                    default: begin
                        n_done = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        n_out.clock_pin     = n_clk;
        n_out.data_pin      = n_data;
        n_out.latch_first   = n_lat[0];
        n_out.latch_second  = n_lat[1];
        n_out.enable_first  = n_en[0];
        n_out.enable_second = n_en[1];
        n_out.busy_res      = (n_step != ST_IDLE);
        n_out.read_word     = n_done ? READ_WORD_W'(n_ishift) : '0;
        n_out.read_done     = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_RESET;
            r_step      <= ST_IDLE;
            r_tick      <= '0;
            r_bits      <= '0;
            r_oshift    <= '0;
            r_ishift    <= '0;
            r_dev       <= 1'b0;
            r_rb        <= 1'b0;
            r_en        <= '0;
            r_lat       <= '0;
            r_clk       <= 1'b0;
            r_data      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_phase <= i_cfg_wr_data;
            if (o_pop) begin
                r_step   <= n_step;
                r_tick   <= n_tick;
                r_bits   <= n_bits;
                r_oshift <= n_oshift;
                r_ishift <= n_ishift;
                r_dev    <= n_dev;
                r_rb     <= n_rb;
                r_en     <= n_en;
                r_lat    <= n_lat;
                r_clk    <= n_clk;
                r_data   <= n_data;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_out <= n_out;
    end

    `TRPM_NEVER(a_enable_sticky, i_clk, i_rst_n, $fell(r_en[0]) || $fell(r_en[1]))
    `TRPM_ASSERT(a_busy_has_enable, i_clk, i_rst_n, (r_step != ST_IDLE) |-> r_en[r_dev])
    `TRPM_ASSERT(a_done_ends_seq, i_clk, i_rst_n, (r_out_valid && r_out.read_done) |-> (!r_out.busy_res && !r_out.clock_pin))
    `TRPM_NEVER(a_idle_latch_low, i_clk, i_rst_n, (r_step == ST_IDLE) && (r_lat != '0) && r_rb)

endmodule

>>> sv/three_wire_register_port_master_top.sv
// top level of the three-wire serial register port master
// Each input beat is one tick of a serial register port master for two radio chips and gives
// exactly one output beat with the pin levels after that tick. The block sustains one beat per
// clock in both directions while the output is not stalled; a beat is registered first in a
// two-entry queue and then in the result register, from which its result is presented.
// Action 1 starts a write of the low WRITE_BITS bits of write_word, action 2 a write
// of the command word followed by a READ_BITS readback; actions are ignored while busy. Every
// pin step lasts phase_ticks beats (0 acts as 1), so a write is busy for
// (2 * WRITE_BITS + 3) * phase_ticks beats and ends on the beat after. Write phase_ticks only
// while no beat is in flight. Input tdata: action[1:0], device[2], write_word[34:3],
// read_sample[35]. Output tdata: clock_pin[0], data_pin[1], latch_first[2], latch_second[3],
// enable_first[4], enable_second[5], busy_res[6], read_word[22:7], read_done[23].
module three_wire_register_port_master_top
    import trpm_pkg::*;
#(
    parameter int WRITE_BITS = WRITE_BITS_DEF,
    parameter int READ_BITS  = READ_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // action, device, write_word, read_sample, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // clock_pin, data_pin, latch_first, latch_second, enable_first,
    // enable_second, busy_res, read_word, read_done
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [PHASE_W-1:0]     i_cfg_wr_data
);

    logic q_ready;
    logic q_push;
    t_cmd front_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    t_res res;

    trpm_front #(
        .WRITE_BITS (WRITE_BITS)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_ready       (q_ready),
        .o_push          (q_push),
        .o_cmd           (front_cmd)
    );

    trpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    trpm_back #(
        .WRITE_BITS (WRITE_BITS),
        .READ_BITS  (READ_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_res         (res)
    );

    assign o_m_axis_tdata = {res.read_done, res.read_word, res.busy_res,
                             res.enable_second, res.enable_first,
                             res.latch_second, res.latch_first,
                             res.data_pin, res.clock_pin};

endmodule

>>> test/tb_three_wire_register_port_master_top.sv
// self-checking testbench for the three-wire register port master top level
module tb_three_wire_register_port_master_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trpm_pkg::*;

    localparam int          CLK_PERIOD  = 4;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          LONG_HOLD   = 40;
    localparam int          REPORT_CAP  = 40;
    localparam int          PLAN_LEN    = 7;
    localparam int          DIRECTED    = 19;
    localparam logic [1:0]  ACT_NONE    = 2'd0;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    // field order: clock, data, latch 1st, latch 2nd, enable 1st, enable 2nd, busy, word, done
    localparam t_res LEVELS_QUIET      = '0;
    localparam t_res LEVELS_CE_SECOND  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0, 1'b0};
    localparam t_res LEVELS_SETUP_HIGH = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0, 1'b0};

    typedef struct {
        logic [1:0]  act;
        logic        dev;
        logic [31:0] word;
        logic        smp;
        bit          typed;
        t_res        want;
    } t_tick_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // action, device, write_word, read_sample, zero pad
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // clock_pin, data_pin, latch_first, latch_second, enable_first,
    // enable_second, busy_res, read_word, read_done
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_wr_en;
    logic [PHASE_W-1:0]     i_cfg_wr_data;

    // port state as the sequencer should hold it
    t_step        step_q;
    logic [15:0]  ticks_q;
    logic [5:0]   bits_q;
    logic [31:0]  out_sr;
    logic [15:0]  in_sr;
    logic         dev_q;
    logic         rb_q;
    logic [1:0]   en_q;
    logic         clk_p, data_p, latch0_p, latch1_p;
    logic [15:0]  phase_cfg;

    t_res pending_levels [$];
    int   mismatches      = 0;
    int   levels_checked  = 0;
    int   ticks_offered   = 0;
    int   writes_started  = 0;
    int   reads_started   = 0;
    int   readbacks_seen  = 0;
    int   cycle_count     = 0;
    int   hold_asked      = 0;
    int   hold_done       = 0;
    int   stall_left      = 0;
    bit   idle_on         = 1'b1;

    three_wire_register_port_master_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_three_wire_register_port_master_top failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t ns beat %0d: %s got %0h want %0h", $time, levels_checked, what, got,
                     want);
    endtask

    // one tick of the sequencer, returns the pin levels after it
    function automatic t_res port_tick(input logic [1:0] act, input logic dev,
                                       input logic [31:0] word, input logic smp);
        logic [15:0] hold;
        logic        done;
        t_res        r;
        hold = (phase_cfg == 16'd0) ? 16'd1 : phase_cfg;
        done = 1'b0;
        if (step_q == ST_IDLE) begin
            if (act == ACT_WRITE || act == ACT_READ) begin
                dev_q   = dev;
                rb_q    = (act == ACT_READ);
                out_sr  = word;
                en_q[dev] = 1'b1;
                ticks_q = 16'd0;
                bits_q  = 6'd0;
                step_q  = ST_CE;
                if (rb_q) reads_started++;
                else writes_started++;
            end
        end else begin
            ticks_q = ticks_q + 16'd1;
            if (ticks_q >= hold) begin
                ticks_q = 16'd0;
                case (step_q)
                    ST_CE: begin
                        if (dev_q) latch1_p = 1'b0;
                        else latch0_p = 1'b0;
                        clk_p  = 1'b0;
                        bits_q = 6'd0;
                        data_p = out_sr[WRITE_BITS_DEF-1];
                        step_q = ST_SETUP;
                    end
                    ST_SETUP: begin
                        clk_p  = 1'b1;
                        step_q = ST_HIGH;
                    end
                    ST_HIGH: begin
                        clk_p  = 1'b0;
                        out_sr = out_sr << 1;
                        bits_q = bits_q + 6'd1;
                        if (bits_q >= WRITE_BITS_DEF) begin
                            step_q = ST_TAIL;
                        end else begin
                            data_p = out_sr[WRITE_BITS_DEF-1];
                            step_q = ST_SETUP;
                        end
                    end
                    ST_TAIL: begin
                        if (dev_q) latch1_p = 1'b1;
                        else latch0_p = 1'b1;
                        step_q = ST_LATCH;
                    end
                    ST_LATCH: begin
                        if (dev_q) latch1_p = 1'b0;
                        else latch0_p = 1'b0;
                        if (rb_q) begin
                            clk_p  = 1'b0;
                            data_p = 1'b1;
                            step_q = ST_RB_PREP;
                        end else begin
                            step_q = ST_IDLE;
                        end
                    end
                    ST_RB_PREP: begin
                        clk_p  = 1'b1;
                        step_q = ST_RB_DUMMY;
                    end
                    ST_RB_DUMMY: begin
                        clk_p  = 1'b0;
                        data_p = 1'b0;
                        if (dev_q) latch1_p = 1'b1;
                        else latch0_p = 1'b1;
                        in_sr  = 16'd0;
                        bits_q = 6'd0;
                        step_q = ST_RB_LATCH;
                    end
                    ST_RB_LATCH: begin
                        clk_p  = 1'b1;
                        step_q = ST_RB_HIGH;
                    end
                    ST_RB_HIGH: begin
                        // sampled on the last tick of the clock-high step
                        in_sr  = {in_sr[14:0], smp};
                        bits_q = bits_q + 6'd1;
                        clk_p  = 1'b0;
                        step_q = ST_RB_LOW;
                    end
                    ST_RB_LOW: begin
                        clk_p  = 1'b1;
                        step_q = (bits_q >= READ_BITS_DEF) ? ST_RB_END : ST_RB_HIGH;
                    end
                    ST_RB_END: begin
                        if (dev_q) latch1_p = 1'b0;
                        else latch0_p = 1'b0;
                        clk_p  = 1'b0;
                        done   = 1'b1;
                        step_q = ST_IDLE;
                    end
                    default: begin
                        step_q = ST_IDLE;
                    end
                endcase
            end
        end
        r.clock_pin     = clk_p;
        r.data_pin      = data_p;
        r.latch_first   = latch0_p;
        r.latch_second  = latch1_p;
        r.enable_first  = en_q[0];
        r.enable_second = en_q[1];
        r.busy_res      = (step_q != ST_IDLE);
        r.read_word     = done ? in_sr : 16'd0;
        r.read_done     = done;
        return r;
    endfunction

    task automatic check_levels(input logic [OUT_TDATA_W-1:0] beat);
        t_res got;
        t_res want;
        got.clock_pin     = beat[0];
        got.data_pin      = beat[1];
        got.latch_first   = beat[2];
        got.latch_second  = beat[3];
        got.enable_first  = beat[4];
        got.enable_second = beat[5];
        got.busy_res      = beat[6];
        got.read_word     = beat[22:7];
        got.read_done     = beat[23];
        if (pending_levels.size() == 0) begin
            report_mismatch("beat with nothing pending", 32'(beat), 32'd0);
            return;
        end
        want = pending_levels.pop_front();
        if (got.clock_pin !== want.clock_pin)
            report_mismatch("clock_pin", 32'(got.clock_pin), 32'(want.clock_pin));
        if (got.data_pin !== want.data_pin)
            report_mismatch("data_pin", 32'(got.data_pin), 32'(want.data_pin));
        if (got.latch_first !== want.latch_first)
            report_mismatch("latch_first", 32'(got.latch_first), 32'(want.latch_first));
        if (got.latch_second !== want.latch_second)
            report_mismatch("latch_second", 32'(got.latch_second), 32'(want.latch_second));
        if (got.enable_first !== want.enable_first)
            report_mismatch("enable_first", 32'(got.enable_first), 32'(want.enable_first));
        if (got.enable_second !== want.enable_second)
            report_mismatch("enable_second", 32'(got.enable_second), 32'(want.enable_second));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.read_word !== want.read_word)
            report_mismatch("read_word", 32'(got.read_word), 32'(want.read_word));
        if (got.read_done !== want.read_done)
            report_mismatch("read_done", 32'(got.read_done), 32'(want.read_done));
        if (want.read_done) readbacks_seen++;
        levels_checked++;
    endtask

    // output side: checks every beat and stalls in bursts or on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_levels(o_m_axis_tdata);
            if (hold_asked != hold_done) begin
                hold_done  = hold_asked;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left != 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic offer_tick(input logic [1:0] act, input logic dev, input logic [31:0] word,
                              input logic smp, input bit typed, input t_res want);
        t_res pred;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, smp, word, dev, act};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = port_tick(act, dev, word, smp);
        pending_levels.push_back(typed ? want : pred);
        ticks_offered++;
    endtask

    task automatic wait_levels_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_phase_ticks(input logic [15:0] value);
        wait_levels_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        phase_cfg = value;
    endtask

    initial begin : stimulus
        t_tick_row   directed_ticks [DIRECTED];
        logic [15:0] plan_phase [PLAN_LEN];
        int          plan_ticks [PLAN_LEN];
        logic [1:0]  act;
        logic [31:0] word;
        int          pick;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;

        step_q    = ST_IDLE;
        ticks_q   = 16'd0;
        bits_q    = 6'd0;
        out_sr    = 32'd0;
        in_sr     = 16'd0;
        dev_q     = 1'b0;
        rb_q      = 1'b0;
        en_q      = 2'b00;
        clk_p     = 1'b0;
        data_p    = 1'b0;
        latch0_p  = 1'b0;
        latch1_p  = 1'b0;
        phase_cfg = PHASE_RESET;

        // reset phase of 4: the start tick plus three more stay in the enable step
        directed_ticks = '{
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b0, 1'b1, LEVELS_QUIET},
            '{ACT_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, LEVELS_QUIET},
            '{ACT_WRITE,  1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, LEVELS_CE_SECOND},
            '{ACT_READ,   1'b0, 32'h0000_0000, 1'b0, 1'b1, LEVELS_CE_SECOND},
            '{ACT_WRITE,  1'b0, 32'h0000_0000, 1'b1, 1'b1, LEVELS_CE_SECOND},
            '{ACT_NONE,   1'b1, 32'h0000_0000, 1'b0, 1'b1, LEVELS_CE_SECOND},
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b0, 1'b1, LEVELS_SETUP_HIGH},
            '{ACT_UNUSED, 1'b0, 32'h8000_0001, 1'b1, 1'b0, LEVELS_QUIET},
            '{ACT_READ,   1'b1, 32'h7FFF_FFFE, 1'b0, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b1, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, LEVELS_QUIET},
            '{ACT_WRITE,  1'b1, 32'hA5A5_5A5A, 1'b1, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b0, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b1, 1'b0, LEVELS_QUIET},
            '{ACT_READ,   1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b1, 32'h0000_0000, 1'b0, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b1, 1'b0, LEVELS_QUIET},
            '{ACT_UNUSED, 1'b1, 32'h0000_0000, 1'b0, 1'b0, LEVELS_QUIET},
            '{ACT_NONE,   1'b0, 32'h0000_0000, 1'b0, 1'b0, LEVELS_QUIET}
        };

        // zero first (acts as one), the top value mid-sequence, a random small one, then one
        plan_phase = '{16'd0, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd2, 16'd1};
        plan_ticks = '{200, 250, 150, 100, 30, 120, 300};
        plan_phase[5] = 16'($urandom_range(2, 6));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_ticks[i])
            offer_tick(directed_ticks[i].act, directed_ticks[i].dev, directed_ticks[i].word,
                       directed_ticks[i].smp, directed_ticks[i].typed, directed_ticks[i].want);

        for (int p = 0; p < PLAN_LEN; p++) begin
            set_phase_ticks(plan_phase[p]);
            if (p == PLAN_LEN - 1) idle_on = 1'b0;
            for (int n = 0; n < plan_ticks[p]; n++) begin
                if (p == 1 && n == 100) hold_asked++;
                if (p == 1 && n == 180) wait_levels_drained();
                // mostly start a new sequence as soon as the port is free
                pick = $urandom_range(0, 9);
                if (step_q == ST_IDLE && pick < 7)
                    act = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
                else if (pick == 0)
                    act = ACT_UNUSED;
                else if (pick == 1)
                    act = ($urandom_range(0, 1) != 0) ? ACT_READ : ACT_WRITE;
                else
                    act = ACT_NONE;
                case ($urandom_range(0, 7))
                    0:       word = 32'h0000_0000;
                    1:       word = 32'hFFFF_FFFF;
                    default: word = $urandom;
                endcase
                offer_tick(act, 1'($urandom_range(0, 1)), word, 1'($urandom_range(0, 1)),
                           1'b0, LEVELS_QUIET);
            end
        end

        wait_levels_drained();
        repeat (8) @(posedge i_clk);
        if (pending_levels.size() != 0)
            report_mismatch("beats still pending", pending_levels.size(), 32'd0);

        $display("covered %0d ticks: %0d register writes and %0d readbacks started, %0d words read",
                 ticks_offered, writes_started, reads_started, readbacks_seen);
        $display("phase settings 4, 0, 1, 2, 3, 65535 and %0d, with a long output stall",
                 plan_phase[5]);
        if (mismatches == 0)
            $display("tb_three_wire_register_port_master_top passed");
        else
            $display("tb_three_wire_register_port_master_top failed");
        $finish;
    end

endmodule
